### sv/ffa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes of the first-fit free block allocator.
package ffa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 24;
    localparam int SUM_W      = 30;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int S_DATA_W   = ((ADDR_W + SIZE_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ADDR_W + 2 + CNT_W + SUM_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Request kinds carried in s_tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Write and read request to the block list memory.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [ADDR_W-1:0] wstart;
        logic [SIZE_W-1:0] wlen;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    // Result of one fit check by the shared compare/subtract unit.
    typedef struct packed {
        logic              fits;
        logic              exact;
        logic [ADDR_W-1:0] new_start;
        logic [SIZE_W-1:0] new_len;
    } fit_t;

endpackage

### sv/ffa_list_mem.sv
`timescale 1ns / 1ps
// Block list memory: start address and word count per ring slot, one write and one read port.
module ffa_list_mem
    import ffa_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [ADDR_W-1:0] rd_start,
    output logic [SIZE_W-1:0] rd_len
);

    logic [ADDR_W-1:0] start_mem [MAX_BLOCKS];
    logic [SIZE_W-1:0] len_mem   [MAX_BLOCKS];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            start_mem[req.waddr] <= req.wstart;
            len_mem[req.waddr]   <= req.wlen;
        end
        rd_start <= start_mem[req.raddr];
        rd_len   <= len_mem[req.raddr];
    end

endmodule

### sv/ffa_fit_unit.sv
`timescale 1ns / 1ps
// Shared fit unit: compares a block against the request and forms the shrunk block.
module ffa_fit_unit
    import ffa_pkg::*;
(
    input  logic [ADDR_W-1:0] blk_start,
    input  logic [SIZE_W-1:0] blk_len,
    input  logic [SIZE_W-1:0] req_words,
    output fit_t              fit
);

    always_comb begin
        fit.fits      = (blk_len >= req_words);
        fit.exact     = (blk_len == req_words);
        // Start wraps modulo 2^ADDR_W.
        fit.new_start = blk_start + ADDR_W'(req_words);
        fit.new_len   = blk_len - req_words;
    end

endmodule

### sv/first_fit_free_block_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit free block allocator: sequencer, totals and result register.
//
// Keeps up to MAX_BLOCKS free blocks as an ordered list in a ring buffer. A free request
// (s_tuser = 1) places the block at the head in a single write and is dropped with a flag when
// the list is full. An allocate (s_tuser = 0) walks the list from the head through one
// shared compare/subtract unit, one block per cycle, and takes the first block that is
// large enough; a larger block shrinks from the front, an exact fit is removed by moving
// the blocks ahead of it back by one, again one per cycle through the single memory port.
// An allocate stops its walk at the first block that fits or at the end of the list; one on an
// empty list goes straight to its result with no grant.
// One request is in flight at a time; the next is taken as soon as the previous result is
// in the output register, even while that beat still waits for m_tready. Every request
// yields exactly one result beat carrying the block count and total free words after it.
module first_fit_free_block_allocator
    import ffa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    // [31:0] block_address, [55:32] block_words
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic [0:0]          s_tuser,
    // Result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    // [31:0] grant_address, [32] granted, [33] dropped, [40:34] block_count,
    // [70:41] free_words_total
    output logic [M_DATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SHIFT,
        ST_SHIFT_LAST,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SIZE_W-1:0]   words_reg, words_next;
    logic [CNT_W-1:0]    rd_pos_reg, rd_pos_next;
    logic                dval_reg, dval_next;
    logic [IDX_W-1:0]    src_reg, src_next;
    logic [IDX_W-1:0]    dst_reg, dst_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   grant_reg, grant_next;
    logic                got_reg, got_next;
    logic                drop_reg, drop_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    mem_req_t          mem_req;
    logic [ADDR_W-1:0] rd_start;
    logic [SIZE_W-1:0] rd_len;
    fit_t              fit;

    logic              accept;
    logic [CNT_W-1:0]  chk_pos;
    logic [SIZE_W-1:0] in_words;
    logic [ADDR_W-1:0] in_addr;

    ffa_list_mem u_mem (
        .aclk     (aclk),
        .req      (mem_req),
        .rd_start (rd_start),
        .rd_len   (rd_len)
    );

    ffa_fit_unit u_fit (
        .blk_start (rd_start),
        .blk_len   (rd_len),
        .req_words (words_reg),
        .fit       (fit)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_words = s_tdata[ADDR_W +: SIZE_W];
    // List position whose data the memory returns this cycle during the walk.
    assign chk_pos  = rd_pos_reg - CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        words_next    = words_reg;
        rd_pos_next   = rd_pos_reg;
        dval_next     = dval_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        pend_next     = pend_reg;
        grant_next    = grant_reg;
        got_next      = got_reg;
        drop_next     = drop_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        mem_req.we     = 1'b0;
        mem_req.waddr  = head_reg;
        mem_req.wstart = rd_start;
        mem_req.wlen   = rd_len;
        mem_req.raddr  = head_reg + rd_pos_reg[IDX_W-1:0];

        // Retire the beat in the output register once it is taken.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    words_next = in_words;
                    grant_next = '0;
                    got_next   = 1'b0;
                    drop_next  = 1'b0;
                    state_next = ST_DONE;
                    if (s_tuser[0] == OP_FREE) begin
                        if (count_reg == CNT_W'(MAX_BLOCKS)) begin
                            drop_next = 1'b1;
                        end else begin
                            // Grow the ring backward: new head slot.
                            mem_req.we     = 1'b1;
                            mem_req.waddr  = head_reg - IDX_W'(1);
                            mem_req.wstart = in_addr;
                            mem_req.wlen   = in_words;
                            head_next      = head_reg - IDX_W'(1);
                            count_next     = count_reg + CNT_W'(1);
                            sum_next       = sum_reg + SUM_W'(in_words);
                        end
                    end else if (count_reg != '0) begin
                        rd_pos_next = '0;
                        dval_next   = 1'b0;
                        state_next  = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                // Issue the next read while checking the previous one.
                rd_pos_next = rd_pos_reg + CNT_W'(1);
                dval_next   = 1'b1;
                if (dval_reg) begin
                    if (fit.fits) begin
                        grant_next = rd_start;
                        got_next   = 1'b1;
                        sum_next   = sum_reg - SUM_W'(words_reg);
                        if (!fit.exact) begin
                            mem_req.we     = 1'b1;
                            mem_req.waddr  = head_reg + chk_pos[IDX_W-1:0];
                            mem_req.wstart = fit.new_start;
                            mem_req.wlen   = fit.new_len;
                            state_next     = ST_DONE;
                        end else if (chk_pos == '0) begin
                            // Head block removed: advance the ring head.
                            head_next  = head_reg + IDX_W'(1);
                            count_next = count_reg - CNT_W'(1);
                            state_next = ST_DONE;
                        end else begin
                            src_next   = chk_pos[IDX_W-1:0] - IDX_W'(1);
                            pend_next  = 1'b0;
                            state_next = ST_SHIFT;
                        end
                    end else if (rd_pos_reg == count_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SHIFT: begin
                // Move blocks ahead of the removed one back by one position.
                mem_req.raddr = head_reg + src_reg;
                if (pend_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = head_reg + dst_reg;
                end
                dst_next  = src_reg + IDX_W'(1);
                pend_next = 1'b1;
                src_next  = src_reg - IDX_W'(1);
                if (src_reg == '0) begin
                    state_next = ST_SHIFT_LAST;
                end
            end

            ST_SHIFT_LAST: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = head_reg + dst_reg;
                head_next     = head_reg + IDX_W'(1);
                count_next    = count_reg - CNT_W'(1);
                state_next    = ST_DONE;
            end

            ST_DONE: begin
                // Hold until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({sum_reg, count_reg, drop_reg, got_reg,
                                               grant_reg});
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        words_reg   <= words_next;
        rd_pos_reg  <= rd_pos_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        grant_reg   <= grant_next;
        got_reg     <= got_next;
        drop_reg    <= drop_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            dval_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            dval_reg     <= dval_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    localparam int GOT_BIT  = ADDR_W;
    localparam int DROP_BIT = ADDR_W + 1;
    localparam int CNT_LSB  = ADDR_W + 2;
    localparam int SUM_LSB  = CNT_LSB + CNT_W;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count exceeds table size");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_grant_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[GOT_BIT] && m_tdata_reg[DROP_BIT]))
        else $error("result both granted and dropped");

    a_empty_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[CNT_LSB +: CNT_W] == '0)
            |-> m_tdata_reg[SUM_LSB +: SUM_W] == '0)
        else $error("empty list reports free words");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[DROP_BIT])
            |-> m_tdata_reg[CNT_LSB +: CNT_W] == CNT_W'(MAX_BLOCKS))
        else $error("block dropped while table not full");

endmodule
